### rtl/pcf_pkg.sv
package pcf_pkg;

  // Page size in data bytes (power of two, 64 to 4096)
  localparam int unsigned PAGE_BYTES     = 4096;
  localparam int unsigned CRC_GAP_BYTES  = 4;
  localparam int unsigned POSITION_WIDTH = 32;

  // Internal position width: positions saturate at 32 bits at most
  localparam int unsigned POS_W  = (POSITION_WIDTH < 32) ? POSITION_WIDTH : 32;
  // Page fill and limit must hold PAGE_BYTES itself
  localparam int unsigned FILL_W = $clog2(PAGE_BYTES + 1);

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PHASE_W = 12;
  localparam int unsigned CRC_W   = 32;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned LEN_W   = 13;

  localparam logic [CRC_W-1:0] CRC_POLY_REFL = 32'h82F6_3B78;
  localparam logic [CRC_W-1:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [POS_W-1:0] POS_LIMIT     = {POS_W{1'b1}};

  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               first_byte;
    logic [PHASE_W-1:0] page_phase;
    logic               last_byte;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0] data_position;
    logic             crc_done;
    logic [CRC_W-1:0] crc_value;
    logic [OUT_W-1:0] gap_position;
    logic [LEN_W-1:0] page_length;
    logic [OUT_W-1:0] encoded_total;
    logic             end_of_read;
  } result_t;

endpackage

### rtl/paged_crc32c_framer.sv
// Channel | Signals                                  | Beat
// --------+------------------------------------------+------------------------------
// input   | in_valid_i, in_ready_o, in_data_i        | one file byte + read flags
// output  | out_valid_o, out_ready_i, out_data_o     | wire position, page CRC info
//
// One beat in, one beat out; sustained rate one beat per cycle while out_ready_i stays high.
// Path: input register, then page/CRC logic into the result register.
// The byte-wide CRC32c fold and the saturating cursor adds set the longest register-to-register path.
// Reset restores page size limit, all-ones CRC and zeroed cursors; no clearing pass.
// An output stall holds the result register; the input register drains into it as
// soon as it frees, so in_ready_o stays high while the result is taken each cycle.
module paged_crc32c_framer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pcf_pkg::item_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pcf_pkg::result_t out_data_o
);

  logic             s1_valid_q;
  pcf_pkg::item_t   s1_item_q;
  logic             out_valid_q;
  pcf_pkg::result_t out_data_q;

  logic             out_free;
  logic             s1_adv;
  pcf_pkg::result_t page_result;

  // The result register frees when empty or being taken this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  // Page state advances only when the staged beat moves into the result register
  pcf_page_ctl u_page_ctl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_adv),
    .item_i   (s1_item_q),
    .result_o (page_result)
  );

  // Input stage: hold control under reset, payload without
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_data_i;
    end
  end

  // Result stage: load on advance, drop valid when taken with nothing behind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= page_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A read's final beat always closes its page
  a_eor_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_read |-> out_data_o.crc_done)
    else $error("end of read without page close");

  // Closed pages carry a length between one byte and a full page
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.crc_done |->
      (out_data_o.page_length != '0) &&
      (out_data_o.page_length <= pcf_pkg::LEN_W'(pcf_pkg::PAGE_BYTES)))
    else $error("page length out of range");

  // Page fields stay clear on beats that close no page
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.crc_done |->
      (out_data_o.crc_value == '0) && (out_data_o.page_length == '0) &&
      (out_data_o.gap_position == '0) && (out_data_o.encoded_total == '0))
    else $error("page fields set without page close");

  // The gap of a closed page never lies after its last data byte
  a_gap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.crc_done |->
      out_data_o.gap_position <= out_data_o.data_position)
    else $error("gap position beyond data position");

endmodule

### rtl/pcf_crc_fold.sv
// Fold one byte into a reflected CRC32c remainder, one bit per step.
module pcf_crc_fold (
  input  logic [pcf_pkg::CRC_W-1:0]  crc_i,
  input  logic [pcf_pkg::BYTE_W-1:0] byte_i,
  output logic [pcf_pkg::CRC_W-1:0]  crc_o
);

  always_comb begin
    logic [pcf_pkg::CRC_W-1:0] c;
    c = crc_i ^ {{(pcf_pkg::CRC_W - pcf_pkg::BYTE_W){1'b0}}, byte_i};
    for (int i = 0; i < pcf_pkg::BYTE_W; i++) begin
      c = c[0] ? ((c >> 1) ^ pcf_pkg::CRC_POLY_REFL) : (c >> 1);
    end
    crc_o = c;
  end

endmodule

### rtl/pcf_page_ctl.sv
// Page and wire cursor state; computes one result per item and updates on advance.
module pcf_page_ctl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  pcf_pkg::item_t   item_i,
  output pcf_pkg::result_t result_o
);

  localparam int unsigned SUM_W = pcf_pkg::POS_W + 1;

  logic [pcf_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [pcf_pkg::FILL_W-1:0] limit_q, limit_d;
  logic [pcf_pkg::CRC_W-1:0]  crc_q, crc_d;
  logic [pcf_pkg::POS_W-1:0]  wire_q, wire_d;
  logic [pcf_pkg::POS_W-1:0]  gap_q, gap_d;
  logic [pcf_pkg::POS_W-1:0]  enc_q, enc_d;

  logic [pcf_pkg::FILL_W-1:0] fill0, limit0, fill1, phase_mod;
  logic [pcf_pkg::CRC_W-1:0]  crc0, crc1, crc2;
  logic [pcf_pkg::POS_W-1:0]  wire0, wire1, gap0, gap1, enc0, enc1, data_pos;
  logic [SUM_W-1:0]           sum_gap, sum_byte, sum_enc;
  logic                       open_page, close_page;

  pcf_crc_fold u_fold (
    .crc_i  (crc1),
    .byte_i (item_i.data_byte),
    .crc_o  (crc2)
  );

  always_comb begin
    // Restart cursors on the first beat of a read
    phase_mod = pcf_pkg::FILL_W'(item_i.page_phase)
              & pcf_pkg::FILL_W'(pcf_pkg::PAGE_BYTES - 1);
    fill0  = item_i.first_byte ? '0 : fill_q;
    limit0 = item_i.first_byte ? pcf_pkg::FILL_W'(pcf_pkg::PAGE_BYTES) - phase_mod
                               : limit_q;
    crc0   = item_i.first_byte ? pcf_pkg::CRC_INIT : crc_q;
    wire0  = item_i.first_byte ? '0 : wire_q;
    gap0   = item_i.first_byte ? '0 : gap_q;
    enc0   = item_i.first_byte ? '0 : enc_q;

    // Open a page: reserve the CRC gap ahead of its data
    open_page = (fill0 == '0);
    sum_gap   = SUM_W'(wire0) + SUM_W'(pcf_pkg::CRC_GAP_BYTES);
    gap1      = open_page ? wire0 : gap0;
    wire1     = !open_page ? wire0 :
                (sum_gap >= SUM_W'(pcf_pkg::POS_LIMIT)) ? pcf_pkg::POS_LIMIT
                                                         : sum_gap[pcf_pkg::POS_W-1:0];
    crc1      = open_page ? pcf_pkg::CRC_INIT : crc0;

    data_pos = wire1;
    sum_byte = SUM_W'(wire1) + SUM_W'(1);
    fill1    = fill0 + pcf_pkg::FILL_W'(1);

    close_page = (fill1 >= limit0) || item_i.last_byte;
    sum_enc    = SUM_W'(enc0) + SUM_W'(pcf_pkg::CRC_GAP_BYTES) + SUM_W'(fill1);
    enc1       = !close_page ? enc0 :
                 (sum_enc >= SUM_W'(pcf_pkg::POS_LIMIT)) ? pcf_pkg::POS_LIMIT
                                                          : sum_enc[pcf_pkg::POS_W-1:0];

    wire_d  = (sum_byte >= SUM_W'(pcf_pkg::POS_LIMIT)) ? pcf_pkg::POS_LIMIT
                                                       : sum_byte[pcf_pkg::POS_W-1:0];
    gap_d   = gap1;
    enc_d   = enc1;
    fill_d  = close_page ? '0 : fill1;
    limit_d = close_page ? pcf_pkg::FILL_W'(pcf_pkg::PAGE_BYTES) : limit0;
    crc_d   = close_page ? pcf_pkg::CRC_INIT : crc2;

    result_o.data_position = pcf_pkg::OUT_W'(data_pos);
    result_o.crc_done      = close_page;
    result_o.crc_value     = close_page ? ~crc2 : '0;
    result_o.gap_position  = close_page ? pcf_pkg::OUT_W'(gap1) : '0;
    result_o.page_length   = close_page ? pcf_pkg::LEN_W'(fill1) : '0;
    result_o.encoded_total = close_page ? pcf_pkg::OUT_W'(enc1) : '0;
    result_o.end_of_read   = item_i.last_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      limit_q <= pcf_pkg::FILL_W'(pcf_pkg::PAGE_BYTES);
      crc_q   <= pcf_pkg::CRC_INIT;
      wire_q  <= '0;
      gap_q   <= '0;
      enc_q   <= '0;
    end else if (adv_i) begin
      fill_q  <= fill_d;
      limit_q <= limit_d;
      crc_q   <= crc_d;
      wire_q  <= wire_d;
      gap_q   <= gap_d;
      enc_q   <= enc_d;
    end
  end

endmodule

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcf_pkg::*;

  // Run length guard for the watchdog below.
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned RANDOM_BEATS  = 850;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned LONG_READ_LEN = 200;
  localparam int unsigned LONG_PHASE    = PAGE_BYTES - 60;

  // Expected wire layout of each accepted file byte, tracked in order.
  class page_crc_scoreboard;
    logic [FILL_W-1:0] page_fill;
    logic [FILL_W-1:0] page_limit;
    logic [CRC_W-1:0]  crc_acc;
    logic [POS_W-1:0]  wire_cursor;
    logic [POS_W-1:0]  gap_base;
    logic [POS_W-1:0]  encoded_count;
    result_t           layout_q[$];
    int unsigned       errors;
    int unsigned       beats_checked;
    int unsigned       pages_closed;
    int unsigned       reads_started;

    function new();
      page_fill     = '0;
      page_limit    = FILL_W'(PAGE_BYTES);
      crc_acc       = CRC_INIT;
      wire_cursor   = '0;
      gap_base      = '0;
      encoded_count = '0;
      errors        = 0;
      beats_checked = 0;
      pages_closed  = 0;
      reads_started = 0;
    endfunction

    // Clamp cursor growth at the top of the position range.
    function logic [POS_W-1:0] sat_add(logic [POS_W-1:0] base, int unsigned inc);
      longint unsigned sum;
      sum = 64'(base);
      sum += 64'(inc);
      if (sum >= POS_LIMIT) return POS_LIMIT;
      return sum[POS_W-1:0];
    endfunction

    function logic [CRC_W-1:0] crc_fold(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] b);
      crc ^= {{(CRC_W-BYTE_W){1'b0}}, b};
      for (int i = 0; i < 8; i++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY_REFL) : (crc >> 1);
      end
      return crc;
    endfunction

    function void note_input(item_t it);
      result_t          r;
      logic [POS_W-1:0] data_pos;
      bit               page_closes;
      if (it.first_byte) begin
        page_fill     = '0;
        page_limit    = FILL_W'(PAGE_BYTES - (it.page_phase % PAGE_BYTES));
        crc_acc       = CRC_INIT;
        wire_cursor   = '0;
        gap_base      = '0;
        encoded_count = '0;
        reads_started++;
      end
      // Open a page: reserve its CRC gap ahead of the data.
      if (page_fill == 0) begin
        gap_base    = wire_cursor;
        wire_cursor = sat_add(wire_cursor, CRC_GAP_BYTES);
        crc_acc     = CRC_INIT;
      end
      data_pos    = wire_cursor;
      wire_cursor = sat_add(wire_cursor, 1);
      crc_acc     = crc_fold(crc_acc, it.data_byte);
      page_fill   = page_fill + 1'b1;
      page_closes = (page_fill >= page_limit) || it.last_byte;

      r = '0;
      r.data_position = OUT_W'(data_pos);
      r.end_of_read   = it.last_byte;
      if (page_closes) begin
        encoded_count   = sat_add(encoded_count, CRC_GAP_BYTES + page_fill);
        r.crc_done      = 1'b1;
        r.crc_value     = crc_acc ^ CRC_INIT;
        r.gap_position  = OUT_W'(gap_base);
        r.page_length   = LEN_W'(page_fill);
        r.encoded_total = OUT_W'(encoded_count);
        page_fill       = '0;
        page_limit      = FILL_W'(PAGE_BYTES);
        crc_acc         = CRC_INIT;
      end
      layout_q.push_back(r);
    endfunction

    function int unsigned pending();
      return layout_q.size();
    endfunction

    function void compare_field(string field, longint unsigned want_v,
                                longint unsigned got_v);
      if (want_v != got_v) begin
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (layout_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual 0x%0h", $time, got);
        errors++;
        return;
      end
      want = layout_q.pop_front();
      beats_checked++;
      if (want.crc_done) pages_closed++;
      compare_field("data_position", 64'(want.data_position), 64'(got.data_position));
      compare_field("crc_done",      64'(want.crc_done),      64'(got.crc_done));
      compare_field("crc_value",     64'(want.crc_value),     64'(got.crc_value));
      compare_field("gap_position",  64'(want.gap_position),  64'(got.gap_position));
      compare_field("page_length",   64'(want.page_length),   64'(got.page_length));
      compare_field("encoded_total", 64'(want.encoded_total), 64'(got.encoded_total));
      compare_field("end_of_read",   64'(want.end_of_read),   64'(got.end_of_read));
    endfunction
  endclass

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_ready_o;
  item_t   in_data_i   = '0;
  logic    out_valid_o;
  logic    out_ready_i = 1'b0;
  result_t out_data_o;

  page_crc_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int unsigned beats_sent  = 0;
  // Burst flags: while set, that side runs with no idle cycles at all.
  bit          tx_burst    = 1'b0;
  bit          rx_burst    = 1'b0;

  paged_crc32c_framer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run as a failure if it drags past the cycle limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout with %0d beats still expected", $time, sb.pending());
    $display("paged_crc32c_framer: mismatch");
    $finish;
  end

  function automatic item_t make_item(logic [BYTE_W-1:0] data, logic first,
                                      logic [PHASE_W-1:0] phase, logic last);
    item_t it;
    it.data_byte  = data;
    it.first_byte = first;
    it.page_phase = phase;
    it.last_byte  = last;
    return it;
  endfunction

  // Offer one beat after a random idle gap and hold it until accepted.
  // Valid is only dropped when a gap is drawn, so back-to-back beats keep it high.
  task automatic send_beat(item_t it);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
    beats_sent++;
  endtask

  // Send a run of random file bytes; the flags choose which read markers it carries.
  task automatic send_read(int unsigned phase, int unsigned len, bit with_first,
                           bit with_last);
    item_t it;
    for (int unsigned i = 0; i < len; i++) begin
      it.data_byte  = BYTE_W'($urandom);
      it.first_byte = with_first && (i == 0);
      it.page_phase = (i == 0) ? PHASE_W'(phase) : PHASE_W'($urandom);
      it.last_byte  = with_last && (i == len - 1);
      send_beat(it);
    end
  endtask

  // Hold the sender idle until every outstanding beat has come back.
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Result side: stall a random number of cycles before each beat.
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
      stall = rx_burst ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Check every result beat taken at this edge against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  initial begin
    int unsigned phase;
    int unsigned len;
    int unsigned random_start;
    bit          long_done;
    long_done = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Stray bytes straight after reset: they open an aligned full-size page,
    // and the last byte cuts it short.
    send_beat(make_item(8'h00, 1'b0, 12'hFFF, 1'b0));
    send_beat(make_item(8'hFF, 1'b0, 12'h000, 1'b1));
    // One-byte read at phase zero: full page limit, closed by the last byte.
    send_beat(make_item(8'hFF, 1'b1, 12'h000, 1'b1));
    // Highest phase: a one-byte first page, then a short second page.
    send_beat(make_item(8'h31, 1'b1, 12'hFFF, 1'b0));
    send_read(0, 3, 1'b0, 1'b1);
    // Page boundary and last byte land on the same beat.
    send_beat(make_item(8'h00, 1'b1, 12'hFFE, 1'b0));
    send_beat(make_item(8'hFF, 1'b0, 12'h000, 1'b1));
    // Bytes after a finished read without a new first byte continue the cursors.
    send_read(0, 2, 1'b0, 1'b1);
    // A first byte in mid-read restarts everything; the new read crosses a page.
    send_beat(make_item(8'hA5, 1'b1, 12'h064, 1'b0));
    send_beat(make_item(8'h5A, 1'b0, 12'h000, 1'b0));
    send_beat(make_item(8'h80, 1'b1, 12'hFFD, 1'b0));
    send_read(0, 4, 1'b0, 1'b1);

    // Random part: mostly well-formed reads whose phase sits near a page end,
    // so that short reads cross boundaries; the rest is loose noise.
    random_start = beats_sent;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      if (!long_done && (beats_sent - random_start >= RANDOM_BEATS / 2)) begin
        // Let the pipeline run dry once, then push one long read across a boundary.
        drain_outputs();
        send_read(LONG_PHASE, LONG_READ_LEN, 1'b1, 1'b1);
        long_done = 1'b1;
      end
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          // Noise: any mix of markers, including restarts and orphan bytes.
          repeat ($urandom_range(1, 6)) begin
            send_beat(make_item(BYTE_W'($urandom), $urandom_range(0, 3) == 0,
                                PHASE_W'($urandom), $urandom_range(0, 3) == 0));
          end
        end
        default: begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: phase = PAGE_BYTES - $urandom_range(1, 24);
            5, 6:          phase = 0;
            default:       phase = $urandom_range(0, (1 << PHASE_W) - 1);
          endcase
          len = $urandom_range(1, 40);
          // Now and then drop the last marker to leave a read hanging.
          send_read(phase, len, 1'b1, $urandom_range(0, 19) != 0);
        end
      endcase
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d byte beats over %0d reads, %0d pages closed,",
             sb.beats_checked, sb.reads_started, sb.pages_closed);
    $display("with boundary crossings, short reads, restarts and one long read");
    if (sb.errors == 0) begin
      $display("paged_crc32c_framer: match");
    end else begin
      $display("paged_crc32c_framer: mismatch");
    end
    $finish;
  end

endmodule

### files.f
rtl/pcf_pkg.sv
rtl/pcf_crc_fold.sv
rtl/pcf_page_ctl.sv
rtl/paged_crc32c_framer.sv
test/tb_top.sv
